@@ sv/ptts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg: shared types for the periodic task tick scheduler
// Operation codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SUSPEND = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;

  localparam int DUE_SLOT_W = 3;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request from the slave side
    logic rd_start;  // tick: restart slot walk
    logic cmd_exec;  // apply command and emit its status
    logic rd_en;     // read slot entry at walk index
    logic ev_step;   // evaluate entry, write back, advance
    logic fin_emit;  // emit final tick result
  } ptts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_tick;
    logic out_free;
    logic ev_stall;
    logic idx_last;
  } ptts_status_t;

endpackage

@@ sv/periodic_task_tick_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top: periodic task slot scheduler
// Table of periodic task slots driven by tick and slot-management requests.
//
// Slave side: one request per s_tvalid/s_tready handshake; s_tuser is the
// operation (tick, create, delete, suspend, resume), s_tdata the slot index,
// period and first delay. Master side: one or more results per request, the
// final one flagged by m_tlast; m_tuser marks a due slot in m_tdata.
// A command is latched at acceptance and applied once the output register is
// free. A tick walks the table slot by slot (memory read, then evaluate and
// write back, the steps kept apart by the single-port slot memory).
// Due slots come out in ascending index order, one result register deep.
// Requests are taken only while no request is in progress; a finished result
// waiting in the output register does not block the next request.
// A stalled master side holds the walk at the next due slot; nothing is lost.
// Reset (rst, synchronous) clears all present and ready flags; the block
// accepts a request as soon as reset is released.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top #(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[7:0], period[23:8], first_delay[39:24]
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status[0], due_slot[3:1], zero[7:4]
  output logic [0:0]  m_tuser,   // due_valid[0]
  output logic        m_tlast
);
  import ptts_pkg::*;

  ptts_cmd_t    cmd;
  ptts_status_t status;
  logic         out_status;
  logic [2:0]   out_due_slot;

  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ptts_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_op          (s_tuser),
    .in_slot        (s_tdata[7:0]),
    .in_period      (s_tdata[23:8]),
    .in_first_delay (s_tdata[39:24]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_status     (out_status),
    .out_due_valid  (m_tuser[0]),
    .out_due_slot   (out_due_slot),
    .out_last       (m_tlast)
  );

  assign m_tdata = {4'b0000, out_due_slot, out_status};

endmodule

@@ sv/ptts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ctrl: scheduler sequencer
// One-hot state machine that takes a request, runs a command in one step or
// walks the slot table for a tick, and waits if a result meets a held output.
// ----------------------------------------------------------------------------
module ptts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ptts_pkg::ptts_status_t status,
  output ptts_pkg::ptts_cmd_t    cmd
);
  import ptts_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMD  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_EV   = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_is_tick) begin
            cmd.rd_start = 1'b1;
            state_next   = ST_RD;
          end else begin
            state_next   = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (status.out_free) begin
          cmd.cmd_exec = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EV;
      end
      ST_EV: begin
        if (!status.ev_stall) begin
          cmd.ev_step = 1'b1;
          state_next  = status.idx_last ? ST_FIN : ST_RD;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.fin_emit = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ptts_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_datapath: slot table and result register
// Present/ready flags in flops, period and countdown in a one-port memory,
// the walk index, the held due result and the master-side output register.
// ----------------------------------------------------------------------------
module ptts_datapath #(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ptts_pkg::ptts_cmd_t    cmd,
  output ptts_pkg::ptts_status_t status,
  input  logic [2:0]             in_op,
  input  logic [7:0]             in_slot,
  input  logic [15:0]            in_period,
  input  logic [15:0]            in_first_delay,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_status,
  output logic                   out_due_valid,
  output logic [2:0]             out_due_slot,
  output logic                   out_last
);
  import ptts_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ENT_W = 2 * COUNT_BITS;

  // latched request
  logic [OP_W-1:0]       op_q;
  logic [7:0]            slot_q;
  logic [COUNT_BITS-1:0] period_q;
  logic [COUNT_BITS-1:0] delay_q;

  logic [NUM_SLOTS-1:0]  slot_present;
  logic [NUM_SLOTS-1:0]  slot_ready;

  // entry = {period, countdown}; only used while the slot is ready, so a used
  // entry is always written by a create first
  logic [ENT_W-1:0]      slot_mem [NUM_SLOTS];
  logic [ENT_W-1:0]      rd_data;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;

  logic [IDX_W-1:0]      idx;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_slot;

  logic [IDX_W-1:0]      cmd_idx;
  logic                  in_range;
  logic                  cmd_err;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] cur_period;
  logic [COUNT_BITS-1:0] dec_count;
  logic                  due;
  logic                  out_free;
  logic                  ev_emit;
  logic                  emit;

  assign out_free = !out_valid || out_ready;

  assign cmd_idx  = slot_q[IDX_W-1:0];
  assign in_range = slot_q < 8'(NUM_SLOTS);

  assign cur_count  = rd_data[COUNT_BITS-1:0];
  assign cur_period = rd_data[ENT_W-1:COUNT_BITS];
  assign dec_count  = (cur_count != '0) ? cur_count - COUNT_BITS'(1) : cur_count;
  assign due        = slot_ready[idx] && (dec_count == '0);
  assign ev_emit    = cmd.ev_step && due && pend_valid;
  assign emit       = cmd.cmd_exec || ev_emit || cmd.fin_emit;

  assign status.in_is_tick = (in_op == OP_TICK);
  assign status.out_free   = out_free;
  assign status.ev_stall   = due && pend_valid && !out_free;
  assign status.idx_last   = (idx == IDX_W'(NUM_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= in_op;
      slot_q   <= in_slot;
      period_q <= COUNT_BITS'(in_period);
      delay_q  <= COUNT_BITS'(in_first_delay);
    end
  end

  // command decode
  always_comb begin
    cmd_err = 1'b0;
    if (!in_range) begin
      cmd_err = 1'b1;
    end else begin
      case (op_q)
        OP_CREATE: cmd_err = (period_q == '0);
        OP_DELETE,
        OP_SUSPEND: cmd_err = 1'b0;
        OP_RESUME: cmd_err = !slot_present[cmd_idx];
        default: cmd_err = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_present <= '0;
      slot_ready   <= '0;
    end else if (cmd.cmd_exec && !cmd_err) begin
      case (op_q)
        OP_CREATE: begin
          slot_present[cmd_idx] <= 1'b1;
          slot_ready[cmd_idx]   <= 1'b1;
        end
        OP_DELETE: begin
          slot_present[cmd_idx] <= 1'b0;
          slot_ready[cmd_idx]   <= 1'b0;
        end
        OP_SUSPEND: slot_ready[cmd_idx] <= 1'b0;
        OP_RESUME:  slot_ready[cmd_idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  // memory write: create from the command path, reload/decrement from the walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {cur_period, due ? cur_period : dec_count};
    if (cmd.cmd_exec) begin
      mem_we    = !cmd_err && (op_q == OP_CREATE);
      mem_waddr = cmd_idx;
      mem_wdata = {period_q, delay_q};
    end else if (cmd.ev_step) begin
      mem_we    = slot_ready[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data <= slot_mem[idx];
    end
  end

  // walk index and the due slot held back until we know whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.rd_start) begin
        idx        <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.ev_step) begin
        if (!status.idx_last) begin
          idx <= idx + IDX_W'(1);
        end
        if (due) begin
          pend_valid <= 1'b1;
        end
      end else if (cmd.fin_emit) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_step && due) begin
      pend_slot <= idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_exec) begin
      out_status    <= cmd_err;
      out_due_valid <= 1'b0;
      out_due_slot  <= '0;
      out_last      <= 1'b1;
    end else if (ev_emit) begin
      out_status    <= 1'b0;
      out_due_valid <= 1'b1;
      out_due_slot  <= DUE_SLOT_W'(pend_slot);
      out_last      <= 1'b0;
    end else if (cmd.fin_emit) begin
      out_status    <= 1'b0;
      out_due_valid <= pend_valid;
      out_due_slot  <= pend_valid ? DUE_SLOT_W'(pend_slot) : '0;
      out_last      <= 1'b1;
    end
  end

  a_ready_implies_present: assert property (@(posedge clk) disable iff (rst)
    (slot_ready & ~slot_present) == '0)
    else $error("ready slot without present flag");

  a_no_pend_in_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.cmd_exec |-> !pend_valid)
    else $error("held due slot during a command");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote an untaken result");

  a_fin_clears_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_emit |=> !pend_valid)
    else $error("held due slot survived end of tick");

endmodule

@@ tb/sv/tb_periodic_task_tick_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler_top: self-checking bench for the tick scheduler
// A short directed table covers error answers, field extremes, overwrite,
// suspend/resume and multi-slot ticks. About 300 random requests follow in
// four idling phases. A local slot table predicts each answer, and every
// result on the master side is compared with the oldest awaited one.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler_top;
  import ptts_pkg::*;

  localparam int NUM_SLOTS  = 8;
  localparam int COUNT_BITS = 16;

  localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  localparam int RANDOM_PER_PHASE = 75;
  localparam int NUM_PHASES       = 4;
  localparam int STALL_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 2 * NUM_SLOTS + 24;
  localparam int NUM_ROWS         = 26;

  typedef struct packed {
    logic                  status;
    logic                  due_valid;
    logic [DUE_SLOT_W-1:0] due_slot;
    logic                  last;
  } answer_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [7:0]      slot;
    logic [15:0]     period;
    logic [15:0]     first_delay;
    logic            typed;
    logic            exp_status;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;

  answer_t awaited_answers[$];

  logic                  slot_present [NUM_SLOTS];
  logic                  slot_ready   [NUM_SLOTS];
  logic [COUNT_BITS-1:0] slot_period  [NUM_SLOTS];
  logic [COUNT_BITS-1:0] slot_count   [NUM_SLOTS];

  // typed rows: single answer with due_valid 0 and last 1, only status varies
  table_row_t directed_rows [NUM_ROWS] = '{
    '{OP_TICK,          8'd0,   16'd0,      16'd0,      1'b1, ST_OK},
    '{OP_CREATE,        8'd0,   16'd1,      16'd0,      1'b1, ST_OK},
    '{OP_CREATE,        8'd7,   16'hFFFF,   16'hFFFF,   1'b1, ST_OK},
    '{OP_CREATE,        8'd8,   16'd5,      16'd1,      1'b1, ST_ERR},
    '{OP_CREATE,        8'd255, 16'hFFFF,   16'hFFFF,   1'b1, ST_ERR},
    '{OP_CREATE,        8'd3,   16'd0,      16'd7,      1'b1, ST_ERR},
    '{OP_RESUME,        8'd5,   16'd0,      16'd0,      1'b1, ST_ERR},
    '{OP_DELETE,        8'd6,   16'd0,      16'd0,      1'b1, ST_OK},
    '{OP_SUSPEND,       8'd4,   16'd0,      16'd0,      1'b1, ST_OK},
    '{OP_UNKNOWN_FIRST, 8'd0,   16'd3,      16'd3,      1'b1, ST_ERR},
    '{OP_UNKNOWN_LAST,  8'd255, 16'hFFFF,   16'hFFFF,   1'b1, ST_ERR},
    '{OP_CREATE,        8'd2,   16'd2,      16'd1,      1'b0, ST_OK},
    '{OP_CREATE,        8'd5,   16'd3,      16'd0,      1'b0, ST_OK},
    '{OP_TICK,          8'd0,   16'd0,      16'd0,      1'b0, ST_OK},
    '{OP_SUSPEND,       8'd2,   16'd0,      16'd0,      1'b0, ST_OK},
    '{OP_TICK,          8'd0,   16'd0,      16'd0,      1'b0, ST_OK},
    '{OP_RESUME,        8'd2,   16'd0,      16'd0,      1'b0, ST_OK},
    '{OP_CREATE,        8'd0,   16'd1,      16'd0,      1'b0, ST_OK},
    '{OP_DELETE,        8'd7,   16'd0,      16'd0,      1'b0, ST_OK},
    '{OP_CREATE,        8'd1,   16'd1,      16'd0,      1'b0, ST_OK},
    '{OP_CREATE,        8'd3,   16'd1,      16'd0,      1'b0, ST_OK},
    '{OP_CREATE,        8'd4,   16'd1,      16'd0,      1'b0, ST_OK},
    '{OP_CREATE,        8'd6,   16'd1,      16'd0,      1'b0, ST_OK},
    '{OP_CREATE,        8'd7,   16'd1,      16'd0,      1'b0, ST_OK},
    '{OP_TICK,          8'd0,   16'd0,      16'd0,      1'b0, ST_OK},
    '{OP_TICK,          8'd0,   16'd0,      16'd0,      1'b0, ST_OK}
  };

  periodic_task_tick_scheduler_top #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // applies one request to the local slot table and queues its answers
  task automatic update_slot_table(input logic [OP_W-1:0] op, input logic [7:0] slot,
                                   input logic [15:0] per, input logic [15:0] fd);
    answer_t ans;
    answer_t batch[$];
    logic [2:0] idx;
    ans = '0;
    ans.last = 1'b1;
    idx = slot[2:0];
    if (op == OP_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_ready[i] && slot_count[i] != '0) slot_count[i] = slot_count[i] - 1'b1;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_ready[i] && slot_count[i] == '0) begin
          ans = '0;
          ans.due_valid = 1'b1;
          ans.due_slot = i[DUE_SLOT_W-1:0];
          batch.push_back(ans);
          slot_count[i] = slot_period[i];
        end
      end
      if (batch.size() == 0) begin
        ans = '0;
        ans.last = 1'b1;
        batch.push_back(ans);
      end else begin
        batch[batch.size()-1].last = 1'b1;
      end
      foreach (batch[k]) awaited_answers.push_back(batch[k]);
    end else begin
      ans.status = ST_OK;
      if (op > OP_RESUME || slot >= NUM_SLOTS) begin
        ans.status = ST_ERR;
      end else begin
        case (op)
          OP_CREATE: begin
            if (per == '0) begin
              ans.status = ST_ERR;
            end else begin
              slot_present[idx] = 1'b1;
              slot_ready[idx] = 1'b1;
              slot_period[idx] = per;
              slot_count[idx] = fd;
            end
          end
          OP_DELETE: begin
            slot_present[idx] = 1'b0;
            slot_ready[idx] = 1'b0;
            slot_period[idx] = '0;
            slot_count[idx] = '0;
          end
          OP_SUSPEND: begin
            slot_ready[idx] = 1'b0;
          end
          default: begin
            if (!slot_present[idx]) ans.status = ST_ERR;
            else slot_ready[idx] = 1'b1;
          end
        endcase
      end
      awaited_answers.push_back(ans);
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] slot,
                              input logic [15:0] per, input logic [15:0] fd,
                              input logic typed, input logic exp_status);
    answer_t fixed;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {fd, per, slot};
    do @(posedge clk); while (!s_tready);
    update_slot_table(op, slot, per, fd);
    if (typed) begin
      // the typed answer stands in for the predicted one
      fixed = '0;
      fixed.status = exp_status;
      fixed.last = 1'b1;
      void'(awaited_answers.pop_back());
      awaited_answers.push_back(fixed);
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_answers.size() == 0) begin
        $error("unexpected result: status %0d due_valid %0d due_slot %0d last %0d",
               m_tdata[0], m_tuser[0], m_tdata[3:1], m_tlast);
        error_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (m_tdata[0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[0]);
          error_count++;
        end
        if (m_tuser[0] !== want.due_valid) begin
          $error("due_valid: expected %0d, actual %0d", want.due_valid, m_tuser[0]);
          error_count++;
        end
        if (m_tdata[3:1] !== want.due_slot) begin
          $error("due_slot: expected %0d, actual %0d", want.due_slot, m_tdata[3:1]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_periodic_task_tick_scheduler_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [7:0]      slot;
    logic [15:0]     per;
    logic [15:0]     fd;
    int              pick;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_present[i] = 1'b0;
      slot_ready[i] = 1'b0;
      slot_period[i] = '0;
      slot_count[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].op, directed_rows[r].slot, directed_rows[r].period,
                   directed_rows[r].first_delay, directed_rows[r].typed,
                   directed_rows[r].exp_status);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        slot = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, NUM_SLOTS))
                                          : 8'($urandom_range(NUM_SLOTS - 1, 0));
        pick = $urandom_range(19, 0);
        per = (pick == 0) ? 16'd0 : (pick < 3) ? 16'($urandom) : 16'($urandom_range(6, 1));
        fd = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(6, 0));
        pick = $urandom_range(99, 0);
        if (pick < 40) op = OP_TICK;
        else if (pick < 65) op = OP_CREATE;
        else if (pick < 75) op = OP_DELETE;
        else if (pick < 85) op = OP_SUSPEND;
        else if (pick < 96) op = OP_RESUME;
        else op = 3'($urandom_range(OP_UNKNOWN_LAST, OP_UNKNOWN_FIRST));
        send_request(op, slot, per, fd, 1'b0, ST_OK);
      end
      // hold off until the table has answered everything
      s_tvalid <= 1'b0;
      do @(negedge clk); while (awaited_answers.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_answers.size() == 0) begin
      $display("tb_periodic_task_tick_scheduler_top passed");
    end else begin
      $display("tb_periodic_task_tick_scheduler_top failed");
    end
    $finish;
  end

endmodule
